// File: hw/rtl/ehtc_pkg.sv
package ehtc_pkg;

  localparam int VERTEX_W     = 24;
  localparam int VALUE_W      = 16;
  localparam int MULT_W       = 16;
  localparam int BUCKET_W     = 12;
  localparam int PROD_W       = VERTEX_W + MULT_W;
  localparam int SUM_W        = PROD_W + 1;
  // remainder unit retires this many dividend bits per cycle
  localparam int MOD_RADIX    = 4;
  localparam int MOD_ITERS    = (SUM_W + MOD_RADIX - 1) / MOD_RADIX;
  localparam int MOD_W        = MOD_ITERS * MOD_RADIX;
  localparam int MOD_CNT_W    = $clog2(MOD_ITERS);
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;
  localparam int BUCKET_RESET = 2048;
  localparam int MULT_A_RESET = 7;
  localparam int MULT_B_RESET = 11;

  typedef enum logic [1:0] {
    REG_BUCKET_COUNT = 2'd0,
    REG_MULT_A       = 2'd1,
    REG_MULT_B       = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_PUT    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_INSERTED  = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] found_value;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_HASH,
    S_MOD,
    S_HEAD,
    S_CHECK,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    latch_req;
    logic    mul;
    logic    mod_start;
    logic    load_head;
    logic    follow;
    logic    clear;
    logic    write_head;
    logic    write_link;
    logic    write_fill;
    logic    set_result;
    status_t result;
    logic    take_value;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic  mod_busy;
    logic  mod_done;
    logic  clear_last;
    logic  first;
    logic  slot_empty;
    logic  slot_match;
    logic  next_end;
    logic  steps_max;
    kind_t kind;
    logic  nfs_full;
    logic  nfs_last;
    logic  out_free;
  } sts_t;

endpackage

// File: hw/rtl/ehtc_mod.sv
module ehtc_mod #(
  parameter int REM_W = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ehtc_pkg::SUM_W-1:0]  dividend,
  input  logic [REM_W-1:0]            divisor,
  output logic                        busy,
  output logic                        done,
  output logic [REM_W-1:0]            rem
);

  logic [ehtc_pkg::MOD_W-1:0]     dvd;
  logic [ehtc_pkg::MOD_CNT_W-1:0] cnt;
  logic [REM_W-1:0]               r_step;
  logic [REM_W:0]                 t;
  logic [REM_W-1:0]               rem_q;

  assign done = busy && (cnt == ehtc_pkg::MOD_CNT_W'(ehtc_pkg::MOD_ITERS - 1));
  assign rem  = rem_q;

  // restoring remainder, a few bits per cycle
  always_comb begin
    t = {1'b0, rem_q};
    for (int i = 0; i < ehtc_pkg::MOD_RADIX; i++) begin
      t = {t[REM_W-1:0], dvd[ehtc_pkg::MOD_W-1-i]};
      if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
    end
    r_step = t[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= ehtc_pkg::MOD_W'(dividend);
      rem_q <= '0;
      cnt   <= '0;
    end else if (busy) begin
      dvd   <= dvd << ehtc_pkg::MOD_RADIX;
      rem_q <= r_step;
      cnt   <= cnt + ehtc_pkg::MOD_CNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/ehtc_ctrl.sv
module ehtc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ehtc_pkg::sts_t       sts,
  output ehtc_pkg::cmd_t       cmd
);

  ehtc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ehtc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ehtc_pkg::S_CLEAR: begin
        if (sts.clear_last) state_next = ehtc_pkg::S_IDLE;
      end
      ehtc_pkg::S_IDLE: begin
        if (in_valid) state_next = ehtc_pkg::S_MUL;
      end
      ehtc_pkg::S_MUL:  state_next = ehtc_pkg::S_HASH;
      ehtc_pkg::S_HASH: state_next = ehtc_pkg::S_MOD;
      ehtc_pkg::S_MOD: begin
        if (sts.mod_done) state_next = ehtc_pkg::S_HEAD;
      end
      ehtc_pkg::S_HEAD: state_next = ehtc_pkg::S_CHECK;
      ehtc_pkg::S_CHECK: begin
        priority if (sts.first && sts.slot_empty) begin
          state_next = ehtc_pkg::S_DONE;
        end else if (sts.slot_match) begin
          state_next = ehtc_pkg::S_DONE;
        end else if (!sts.next_end && !sts.steps_max) begin
          state_next = ehtc_pkg::S_CHECK;
        end else if (sts.kind == ehtc_pkg::KIND_LOOKUP) begin
          state_next = ehtc_pkg::S_DONE;
        end else if (!sts.next_end || sts.nfs_full || sts.nfs_last) begin
          state_next = ehtc_pkg::S_DONE;
        end else begin
          state_next = ehtc_pkg::S_FILL;
        end
      end
      ehtc_pkg::S_FILL: state_next = ehtc_pkg::S_DONE;
      ehtc_pkg::S_DONE: begin
        if (sts.out_free) state_next = ehtc_pkg::S_IDLE;
      end
      default: state_next = ehtc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.result = ehtc_pkg::STATUS_FOUND;
    in_ready   = 1'b0;
    unique case (state)
      ehtc_pkg::S_CLEAR: cmd.clear = 1'b1;
      ehtc_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      ehtc_pkg::S_MUL:  cmd.mul = 1'b1;
      ehtc_pkg::S_HASH: cmd.mod_start = 1'b1;
      ehtc_pkg::S_MOD:  ;
      ehtc_pkg::S_HEAD: cmd.load_head = 1'b1;
      ehtc_pkg::S_CHECK: begin
        priority if (sts.first && sts.slot_empty) begin
          cmd.set_result = 1'b1;
          if (sts.kind == ehtc_pkg::KIND_PUT) begin
            cmd.write_head = 1'b1;
            cmd.result     = ehtc_pkg::STATUS_INSERTED;
          end else begin
            cmd.result = ehtc_pkg::STATUS_NOT_FOUND;
          end
        end else if (sts.slot_match) begin
          cmd.set_result = 1'b1;
          cmd.take_value = 1'b1;
          cmd.result     = ehtc_pkg::STATUS_FOUND;
        end else if (!sts.next_end && !sts.steps_max) begin
          cmd.follow = 1'b1;
        end else if (sts.kind == ehtc_pkg::KIND_LOOKUP) begin
          cmd.set_result = 1'b1;
          cmd.result     = ehtc_pkg::STATUS_NOT_FOUND;
        end else if (!sts.next_end || sts.nfs_full) begin
          cmd.set_result = 1'b1;
          cmd.result     = ehtc_pkg::STATUS_FULL;
        end else begin
          cmd.write_link = 1'b1;
          cmd.set_result = 1'b1;
          cmd.result     = sts.nfs_last ? ehtc_pkg::STATUS_FULL
                                        : ehtc_pkg::STATUS_INSERTED;
        end
      end
      ehtc_pkg::S_FILL: cmd.write_fill = 1'b1;
      ehtc_pkg::S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ehtc_dp.sv
module ehtc_dp #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ehtc_pkg::req_t                 in_data,
  output ehtc_pkg::rsp_t                 out_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ehtc_pkg::MULT_W-1:0]    mult_a,
  input  logic [ehtc_pkg::MULT_W-1:0]    mult_b,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] buckets,
  input  logic                           nfs_load,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] nfs_value,
  input  ehtc_pkg::cmd_t                 cmd,
  output ehtc_pkg::sts_t                 sts
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int EW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [ehtc_pkg::VERTEX_W-1:0] min_vertex;
    logic [ehtc_pkg::VERTEX_W-1:0] max_vertex;
    logic [ehtc_pkg::VALUE_W-1:0]  value;
    logic [IW-1:0]                 next;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  entry_t wdata;
  entry_t fresh_entry;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic          we;
  logic          re;

  logic [ehtc_pkg::VERTEX_W-1:0] lo;
  logic [ehtc_pkg::VERTEX_W-1:0] hi;
  logic [ehtc_pkg::VALUE_W-1:0]  val;
  ehtc_pkg::kind_t               kind;
  logic [ehtc_pkg::PROD_W-1:0]   pa;
  logic [ehtc_pkg::PROD_W-1:0]   pb;
  logic [IW-1:0]                 cur;
  logic [IW-1:0]                 fresh;
  logic [IW-1:0]                 clr_idx;
  logic [EW-1:0]                 steps;
  logic [EW-1:0]                 nfs;
  logic                          first;
  ehtc_pkg::rsp_t                res;
  logic                          mod_busy;
  logic                          mod_done;
  logic [EW-1:0]                 rem;

  ehtc_mod #(
    .REM_W (EW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (ehtc_pkg::SUM_W'(pa) + ehtc_pkg::SUM_W'(pb)),
    .divisor  (buckets),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (rem)
  );

  // request latch and hash products
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      kind <= in_data.kind;
      val  <= in_data.value;
      if (in_data.vertex_a < in_data.vertex_b) begin
        lo <= in_data.vertex_a;
        hi <= in_data.vertex_b;
      end else begin
        lo <= in_data.vertex_b;
        hi <= in_data.vertex_a;
      end
    end
    if (cmd.mul) begin
      pa <= ehtc_pkg::PROD_W'(mult_a) * ehtc_pkg::PROD_W'(lo);
      pb <= ehtc_pkg::PROD_W'(mult_b) * ehtc_pkg::PROD_W'(hi);
    end
  end

  // chain walk
  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      cur   <= rem[IW-1:0];
      steps <= '0;
      first <= 1'b1;
    end else if (cmd.follow) begin
      cur   <= rd.next;
      steps <= steps + EW'(1);
      first <= 1'b0;
    end
    if (cmd.write_link) fresh <= nfs[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (nfs_load) begin
      nfs <= nfs_value;
    end else if (cmd.write_link) begin
      nfs <= nfs + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + IW'(1);
    end
  end

  // slot memory, one access a cycle
  assign fresh_entry = '{min_vertex: lo, max_vertex: hi, value: val, next: '0};

  always_comb begin
    we    = 1'b1;
    waddr = cur;
    wdata = fresh_entry;
    priority if (cmd.clear) begin
      waddr = clr_idx;
      wdata = '0;
    end else if (cmd.write_head) begin
      waddr = cur;
    end else if (cmd.write_link) begin
      waddr      = cur;
      wdata      = rd;
      wdata.next = nfs[IW-1:0];
    end else if (cmd.write_fill) begin
      waddr = fresh;
    end else begin
      we = 1'b0;
    end
  end

  assign re    = cmd.load_head || cmd.follow;
  assign raddr = cmd.load_head ? rem[IW-1:0] : rd.next;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  // result and output stage
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res.status      <= cmd.result;
      res.found_value <= cmd.take_value ? rd.value : '0;
    end
    if (cmd.out_load) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts            = '0;
    sts.mod_busy   = mod_busy;
    sts.mod_done   = mod_done;
    sts.clear_last = (clr_idx == IW'(TABLE_DEPTH - 1));
    sts.first      = first;
    sts.slot_empty = (rd.min_vertex == '0);
    sts.slot_match = (rd.min_vertex == lo) && (rd.max_vertex == hi);
    sts.next_end   = (rd.next == '0);
    sts.steps_max  = (steps >= EW'(TABLE_DEPTH));
    sts.kind       = kind;
    sts.nfs_full   = (nfs >= EW'(TABLE_DEPTH));
    sts.nfs_last   = (nfs == EW'(TABLE_DEPTH - 1));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/edge_hash_table_chained_unit.sv
// edge hash table with overflow chaining
// in channel (in_valid/in_ready/in_data): one request names an undirected edge by
//   two vertex ids in either order; kind put finds or inserts, kind lookup only finds
// out channel (out_valid/out_ready/out_data): one result per request, status and
//   the stored value when the edge was found
// apb port: bucket_count at 0x0, mult_a at 0x4, mult_b at 0x8; writing
//   bucket_count also rewinds the overflow free pointer to the first overflow slot
// a request passes the states MUL, HASH, MOD, HEAD and CHECK, CHECK once more for
//   every chain link followed, FILL when a put fills an overflow slot, then DONE; the
//   41-bit remainder unit retires 4 bits a cycle and the slot memory gives one
//   access per cycle, so the chain walk follows one link per CHECK
// one request is worked at a time; the next one is taken as soon as the result has
//   moved into the output register
// reset: the slot memory is swept to zero with in_ready low; apb writes are taken
//   throughout
// a stalled receiver holds the result in the output register; one further request
//   is taken and worked, then waits for the output register to drain
module edge_hash_table_chained_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ehtc_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ehtc_pkg::rsp_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ehtc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ehtc_pkg::DATA_W-1:0]   pwdata,
  output logic [ehtc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // width that holds TABLE_DEPTH itself
  localparam int EW = $clog2(TABLE_DEPTH + 1);
  // compare width for clipping the bucket count
  localparam int CW = (EW > ehtc_pkg::BUCKET_W) ? EW : ehtc_pkg::BUCKET_W;

  logic [ehtc_pkg::BUCKET_W-1:0] bucket_count;
  logic [ehtc_pkg::MULT_W-1:0]   mult_a;
  logic [ehtc_pkg::MULT_W-1:0]   mult_b;
  logic                          wr_en;
  ehtc_pkg::reg_idx_t            reg_idx;
  logic [EW-1:0]                 buckets;
  logic                          nfs_load;
  logic [EW-1:0]                 nfs_value;
  ehtc_pkg::cmd_t                cmd;
  ehtc_pkg::sts_t                sts;

  // effective bucket count: zero forced to one, clipped to the table depth
  function automatic logic [EW-1:0] eff_of(input logic [ehtc_pkg::BUCKET_W-1:0] v);
    logic [CW-1:0] b;
    b = CW'(v);
    if (b == '0) b = CW'(1);
    if (b > CW'(TABLE_DEPTH)) b = CW'(TABLE_DEPTH);
    return EW'(b);
  endfunction

  // register file
  assign pready  = 1'b1;
  assign reg_idx = ehtc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= ehtc_pkg::BUCKET_W'(ehtc_pkg::BUCKET_RESET);
      mult_a       <= ehtc_pkg::MULT_W'(ehtc_pkg::MULT_A_RESET);
      mult_b       <= ehtc_pkg::MULT_W'(ehtc_pkg::MULT_B_RESET);
    end else if (wr_en) begin
      unique case (reg_idx)
        ehtc_pkg::REG_BUCKET_COUNT: bucket_count <= pwdata[ehtc_pkg::BUCKET_W-1:0];
        ehtc_pkg::REG_MULT_A:       mult_a       <= pwdata[ehtc_pkg::MULT_W-1:0];
        ehtc_pkg::REG_MULT_B:       mult_b       <= pwdata[ehtc_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ehtc_pkg::REG_BUCKET_COUNT: prdata = ehtc_pkg::DATA_W'(bucket_count);
      ehtc_pkg::REG_MULT_A:       prdata = ehtc_pkg::DATA_W'(mult_a);
      ehtc_pkg::REG_MULT_B:       prdata = ehtc_pkg::DATA_W'(mult_b);
      default:                    prdata = '0;
    endcase
  end

  assign buckets = eff_of(bucket_count);

  // free pointer follows the bucket count at reset and on every bucket write
  assign nfs_load  = rst || (wr_en && (reg_idx == ehtc_pkg::REG_BUCKET_COUNT));
  assign nfs_value = rst ? eff_of(ehtc_pkg::BUCKET_W'(ehtc_pkg::BUCKET_RESET))
                         : eff_of(pwdata[ehtc_pkg::BUCKET_W-1:0]);

  ehtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ehtc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mult_a    (mult_a),
    .mult_b    (mult_b),
    .buckets   (buckets),
    .nfs_load  (nfs_load),
    .nfs_value (nfs_value),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // a result is never written over one still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while occupied");

  // a chain is only extended while an overflow slot is left
  a_link_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.write_link |-> !sts.nfs_full)
    else $error("chain linked with overflow area exhausted");

  // remainder unit is started only when free
  a_mod_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> !sts.mod_busy)
    else $error("remainder unit restarted while busy");

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ehtc_pkg::*;

  localparam int SLOT_COUNT = 4096;
  // cycles allowed after the last result for anything stray to show up
  localparam int DRAIN_MARGIN = 64;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  req_t                in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rsp_t                out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  edge_hash_table_chained_unit #(
    .TABLE_DEPTH(SLOT_COUNT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the edge table and its registers
  // ---------------------------------------------------------------------------
  bit [BUCKET_W-1:0] cfg_buckets = BUCKET_W'(BUCKET_RESET);
  bit [MULT_W-1:0]   cfg_mult_a = MULT_W'(MULT_A_RESET);
  bit [MULT_W-1:0]   cfg_mult_b = MULT_W'(MULT_B_RESET);
  bit [VERTEX_W-1:0] slot_lo [SLOT_COUNT];
  bit [VERTEX_W-1:0] slot_hi [SLOT_COUNT];
  bit [VALUE_W-1:0]  slot_val [SLOT_COUNT];
  int unsigned       slot_link [SLOT_COUNT];
  int unsigned       free_slot = BUCKET_RESET;

  rsp_t expected_edge_results [$];
  int   fail_count = 0;

  // sender burst state and receiver hold-off handshake with the test sequence
  int burst_left = 0;
  int rx_hold_request = 0;
  int rx_hold_left = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int rx_pattern_left = 0;
  int rx_tick = 0;

  // edges used by the random traffic: families sharing one bucket, plus wide random ids
  bit [VERTEX_W-1:0] edge_pool_lo [$];
  bit [VERTEX_W-1:0] edge_pool_hi [$];

  // zero forced up to one, clipped to the slot count
  function automatic int unsigned active_buckets();
    int unsigned b;
    b = cfg_buckets;
    if (b == 0) b = 1;
    if (b > SLOT_COUNT) b = SLOT_COUNT;
    return b;
  endfunction

  function automatic void store_edge(int unsigned idx, bit [VERTEX_W-1:0] lo,
                                     bit [VERTEX_W-1:0] hi, bit [VALUE_W-1:0] val);
    slot_lo[idx] = lo;
    slot_hi[idx] = hi;
    slot_val[idx] = val;
    slot_link[idx] = 0;
  endfunction

  // find-or-insert / lookup against the shadow table, returns the result due
  function automatic rsp_t edge_table_predict(req_t r);
    bit [VERTEX_W-1:0] lo;
    bit [VERTEX_W-1:0] hi;
    bit [63:0]         sum;
    int unsigned       head;
    int unsigned       cur;
    int unsigned       steps;
    int unsigned       fresh;
    bit                hit;
    bit                cut;
    rsp_t              res;
    lo = (r.vertex_a < r.vertex_b) ? r.vertex_a : r.vertex_b;
    hi = (r.vertex_a < r.vertex_b) ? r.vertex_b : r.vertex_a;
    // full width sum of products, 41 bits at most
    sum = 64'(cfg_mult_a) * 64'(lo) + 64'(cfg_mult_b) * 64'(hi);
    head = 32'(sum % 64'(active_buckets()));
    res.found_value = '0;
    if (slot_lo[head] == 0) begin
      // empty bucket: put claims it, lookup misses
      if (r.kind == KIND_PUT) begin
        store_edge(head, lo, hi, r.value);
        res.status = STATUS_INSERTED;
      end else begin
        res.status = STATUS_NOT_FOUND;
      end
    end else if (slot_lo[head] == lo && slot_hi[head] == hi) begin
      res.status = STATUS_FOUND;
      res.found_value = slot_val[head];
    end else begin
      cur = head;
      steps = 0;
      hit = 1'b0;
      cut = 1'b0;
      // walk the chain, bounded so a cycle cannot hang the walk
      while (slot_link[cur] != 0 && slot_link[cur] < SLOT_COUNT) begin
        if (steps >= SLOT_COUNT) begin
          cut = 1'b1;
          break;
        end
        cur = slot_link[cur];
        steps++;
        if (slot_lo[cur] == lo && slot_hi[cur] == hi) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        res.status = STATUS_FOUND;
        res.found_value = slot_val[cur];
      end else if (r.kind != KIND_PUT) begin
        res.status = STATUS_NOT_FOUND;
      end else if (cut || free_slot >= SLOT_COUNT) begin
        res.status = STATUS_FULL;
      end else begin
        // tail gets linked even when the last overflow slot is used up
        fresh = free_slot;
        slot_link[cur] = fresh;
        free_slot = fresh + 1;
        if (free_slot >= SLOT_COUNT) begin
          res.status = STATUS_FULL;
        end else begin
          store_edge(fresh, lo, hi, r.value);
          res.status = STATUS_INSERTED;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and prediction, both on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_edge_results.size() == 0) begin
        $display("%0t: result with nothing expected: got status %s value %h",
                 $time, out_data.status.name(), out_data.found_value);
        fail_count++;
      end else begin
        want = expected_edge_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %s, actual %s (%h)", $time,
                   want.status.name(), out_data.status.name(), out_data.status);
          fail_count++;
        end
        if (out_data.found_value !== want.found_value) begin
          $display("%0t: found_value mismatch: expected %h, actual %h", $time,
                   want.found_value, out_data.found_value);
          fail_count++;
        end
      end
    end
    // checked above first, so a request taken on this edge never meets its own result
    if (!rst && in_valid && in_ready)
      expected_edge_results.push_back(edge_table_predict(in_data));
  end

  // ---------------------------------------------------------------------------
  // receiver: changing stall patterns, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always begin
    @(negedge clk);
    rx_tick++;
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_pattern_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_pattern_left = $urandom_range(20, 300);
      end
      rx_pattern_left--;
      case (rx_pattern)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
        default:   out_ready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender and register access
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(kind_t k, int unsigned a, int unsigned b, int unsigned v);
    req_t r;
    r.kind = k;
    r.vertex_a = VERTEX_W'(a);
    r.vertex_b = VERTEX_W'(b);
    r.value = VALUE_W'(v);
    return r;
  endfunction

  // offers one request in bursts with random gaps, returns on the accepting edge
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(1, 25);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender pauses until every expected result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_edge_results.size() != 0) @(posedge clk);
  endtask

  // setup then access phase; pready is tied high so the access is never stretched
  task automatic apb_cycle(input logic is_write, input reg_idx_t idx,
                           input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write, mirror into the shadow registers, read back
  task automatic set_register(input reg_idx_t idx, input int unsigned value);
    logic [DATA_W-1:0] readback;
    logic [DATA_W-1:0] held;
    apb_cycle(1'b1, idx, DATA_W'(value), readback);
    case (idx)
      REG_BUCKET_COUNT: begin
        cfg_buckets = BUCKET_W'(value);
        // free pointer rewinds, the store is left alone
        free_slot = active_buckets();
        held = DATA_W'(cfg_buckets);
      end
      REG_MULT_A: begin
        cfg_mult_a = MULT_W'(value);
        held = DATA_W'(cfg_mult_a);
      end
      default: begin
        cfg_mult_b = MULT_W'(value);
        held = DATA_W'(cfg_mult_b);
      end
    endcase
    apb_cycle(1'b0, idx, '0, readback);
    if (readback !== held) begin
      $display("%0t: register %s readback: expected %h, actual %h", $time, idx.name(),
               held, readback);
      fail_count++;
    end
  endtask

  function automatic bit [VERTEX_W-1:0] random_vertex();
    case ($urandom_range(0, 3))
      0:       return VERTEX_W'($urandom_range(1, 32));
      1:       return {VERTEX_W{1'b1}} - VERTEX_W'($urandom_range(0, 3));
      default: return VERTEX_W'($urandom);
    endcase
  endfunction

  // families of edges that all land in one bucket under the current setting
  function automatic void refill_edge_pool(int families, int members);
    bit [VERTEX_W-1:0] lo;
    bit [VERTEX_W-1:0] hi;
    edge_pool_lo.delete();
    edge_pool_hi.delete();
    repeat (families) begin
      lo = VERTEX_W'($urandom_range(1, 1000));
      hi = lo + VERTEX_W'($urandom_range(1, 1000));
      for (int k = 0; k < members; k++) begin
        edge_pool_lo.push_back(lo);
        edge_pool_hi.push_back(hi + VERTEX_W'(k * active_buckets()));
      end
    end
    // a few wide ids to push the hash sum to full width
    repeat (16) begin
      edge_pool_lo.push_back(random_vertex());
      edge_pool_hi.push_back(random_vertex());
    end
  endfunction

  // mostly pool edges in either order, some noise including vertex zero
  function automatic req_t random_edge_request();
    kind_t       k;
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    k = kind_t'($urandom_range(0, 9) < 4);
    if ($urandom_range(0, 99) < 85) begin
      pick = $urandom_range(0, edge_pool_lo.size() - 1);
      a = edge_pool_lo[pick];
      b = edge_pool_hi[pick];
      if ($urandom_range(0, 1)) return make_req(k, b, a, $urandom);
      return make_req(k, a, b, $urandom);
    end
    a = ($urandom_range(0, 9) == 0) ? 0 : random_vertex();
    b = random_vertex();
    return make_req(k, a, b, $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: insert, find in either order, misses, extremes, a short chain
  task automatic test_put_and_lookup();
    send_request(make_req(KIND_PUT, 5, 9, 16'h1234));
    send_request(make_req(KIND_PUT, 9, 5, 16'haaaa));
    send_request(make_req(KIND_LOOKUP, 9, 5, 16'h0000));
    send_request(make_req(KIND_LOOKUP, 5, 10, 16'hffff));
    send_request(make_req(KIND_PUT, 24'hffffff, 24'hfffffe, 16'hffff));
    send_request(make_req(KIND_LOOKUP, 24'hfffffe, 24'hffffff, 16'h5555));
    send_request(make_req(KIND_PUT, 1, 1, 16'h0000));
    send_request(make_req(KIND_LOOKUP, 1, 1, 16'hffff));
    // (1,2), (1,2050), (1,4098) share a bucket at 2048 buckets with multiplier 11
    send_request(make_req(KIND_PUT, 1, 2, 16'h0102));
    send_request(make_req(KIND_PUT, 2050, 1, 16'h0203));
    send_request(make_req(KIND_PUT, 1, 4098, 16'h0304));
    send_request(make_req(KIND_LOOKUP, 4098, 1, 16'h0000));
    send_request(make_req(KIND_LOOKUP, 1, 6146, 16'h0000));
    // vertex zero: stored edge leaves its bucket looking empty
    send_request(make_req(KIND_PUT, 0, 77, 16'h5a5a));
    send_request(make_req(KIND_LOOKUP, 77, 0, 16'h0000));
    send_request(make_req(KIND_PUT, 77, 0, 16'ha5a5));
    wait_for_results();
  endtask

  // overflow area runs out, then pointer rewinds, then a zero bucket count
  task automatic test_overflow_exhaustion();
    set_register(REG_BUCKET_COUNT, 4094);
    set_register(REG_MULT_A, 1);
    set_register(REG_MULT_B, 1);
    // all four hash to bucket 3; only slots 4094 and 4095 are overflow
    send_request(make_req(KIND_PUT, 1, 2, 16'h1111));
    send_request(make_req(KIND_PUT, 1, 4096, 16'h2222));
    send_request(make_req(KIND_PUT, 8190, 1, 16'h3333));
    send_request(make_req(KIND_PUT, 1, 12284, 16'h4444));
    send_request(make_req(KIND_LOOKUP, 1, 12284, 16'h0000));
    send_request(make_req(KIND_LOOKUP, 4096, 1, 16'h0000));
    wait_for_results();
    set_register(REG_BUCKET_COUNT, 4095);
    send_request(make_req(KIND_PUT, 2, 3, 16'h7777));
    send_request(make_req(KIND_PUT, 2, 4098, 16'h8888));
    wait_for_results();
    set_register(REG_BUCKET_COUNT, 0);
    send_request(make_req(KIND_PUT, 7, 8, 16'h0001));
    send_request(make_req(KIND_PUT, 9, 7, 16'h0002));
    send_request(make_req(KIND_LOOKUP, 8, 7, 16'h0000));
    wait_for_results();
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_receiver_hold_off();
    set_register(REG_BUCKET_COUNT, 64);
    set_register(REG_MULT_A, 65535);
    set_register(REG_MULT_B, 65535);
    refill_edge_pool(3, 4);
    rx_hold_request = 400;
    burst_left = 20;
    repeat (12) send_request(random_edge_request());
    wait_for_results();
  endtask

  // phases of random traffic over several table settings
  task automatic test_random_traffic();
    int unsigned phase_buckets [7] = '{1, 16, 4090, 0, 257, 4095, 2048};
    int unsigned phase_mult_a [7] = '{1, 0, 65535, 3, 0, 1, 7};
    int unsigned phase_mult_b [7] = '{1, 0, 65535, 5, 0, 65535, 11};
    int          phase_items [7] = '{60, 150, 100, 40, 200, 100, 200};
    for (int p = 0; p < 7; p++) begin
      // zero in the table means a random multiplier
      set_register(REG_BUCKET_COUNT, phase_buckets[p]);
      set_register(REG_MULT_A, phase_mult_a[p] != 0 ? phase_mult_a[p] : $urandom_range(1, 65535));
      set_register(REG_MULT_B, phase_mult_b[p] != 0 ? phase_mult_b[p] : $urandom_range(1, 65535));
      refill_edge_pool(4, (phase_buckets[p] > 4000) ? 6 : 8);
      for (int i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(0, 79) == 0) wait_for_results();
        send_request(random_edge_request());
      end
      wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // the clearing pass after reset holds in_ready low; send_request waits it out
    test_put_and_lookup();
    test_overflow_exhaustion();
    test_receiver_hold_off();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_MARGIN) @(posedge clk);
    if (fail_count == 0 && expected_edge_results.size() == 0) begin
      $display("edge_hash_table_chained_unit test passed");
    end else begin
      $display("edge_hash_table_chained_unit test failed");
    end
    $finish;
  end

  // overall limit, well above the slowest legal run
  initial begin
    #15ms;
    $display("edge_hash_table_chained_unit test failed");
    $finish;
  end

endmodule
